// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks, clocked on the rising edge, held off while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_IMPL(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/aduu_pkg.sv =====
// ---------------------------------------------------------------------------
// aduu_pkg
// Shared types and constants of the advertising data UUID16 scanner.
// ---------------------------------------------------------------------------
package aduu_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_UUID          = 2'd0,
    REG_LIST_TYPE_COMPLETE   = 2'd1,
    REG_LIST_TYPE_INCOMPLETE = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] TARGET_UUID_RST          = 16'h1814;
  localparam logic [7:0]  LIST_TYPE_COMPLETE_RST   = 8'd3;
  localparam logic [7:0]  LIST_TYPE_INCOMPLETE_RST = 8'd2;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [15:0] target_uuid;
    logic [7:0]  list_type_complete;
    logic [7:0]  list_type_incomplete;
  } cfg_t;

  // verdict handed from the parser to the result buffer
  typedef struct packed {
    logic valid;
    logic found;
  } verdict_t;

endpackage

// ===== sv/aduu_parser.sv =====
// ---------------------------------------------------------------------------
// aduu_parser
// Length-type-value walker: one report byte per transfer, verdict on the
// last byte of the report.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aduu_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  aduu_pkg::cfg_t    cfg,
  output aduu_pkg::verdict_t verdict
);
  import aduu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic        in_list_r, in_list_nxt;
  logic [6:0]  pairs_left_r, pairs_left_nxt;
  logic [7:0]  low_half_r, low_half_nxt;
  logic        half_sel_r, half_sel_nxt;
  logic        found_r, found_nxt;

  logic        is_list;
  logic [6:0]  pairs_dec;

  assign is_list   = (data_byte == cfg.list_type_complete) ||
                     (data_byte == cfg.list_type_incomplete);
  assign pairs_dec = pairs_left_r - 7'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    in_list_nxt    = in_list_r;
    pairs_left_nxt = pairs_left_r;
    low_half_nxt   = low_half_r;
    half_sel_nxt   = half_sel_r;
    found_nxt      = found_r;
    case (phase_r)
      PH_LEN: begin
        if (data_byte == 8'd0) begin
          phase_nxt = PH_DONE;
        end else begin
          bytes_left_nxt = data_byte - 8'd1;
          phase_nxt      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (is_list) begin
          in_list_nxt    = 1'b1;
          pairs_left_nxt = bytes_left_r[7:1];
          half_sel_nxt   = 1'b0;
          phase_nxt      = (bytes_left_r[7:1] == 7'd0) ? PH_DONE : PH_DATA;
        end else begin
          in_list_nxt = 1'b0;
          phase_nxt   = (bytes_left_r == 8'd0) ? PH_LEN : PH_DATA;
        end
      end
      PH_DATA: begin
        if (in_list_r) begin
          if (!half_sel_r) begin
            low_half_nxt = data_byte;
            half_sel_nxt = 1'b1;
          end else begin
            half_sel_nxt = 1'b0;
            if ({data_byte, low_half_r} == cfg.target_uuid) begin
              found_nxt = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              pairs_left_nxt = pairs_dec;
              if (pairs_dec == 7'd0) begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end else begin
          bytes_left_nxt = bytes_left_r - 8'd1;
          if (bytes_left_r == 8'd1) begin
            phase_nxt = PH_LEN;
          end
        end
      end
      PH_DONE: begin
        // search decided: bytes are dropped until the report ends
      end
      default: begin
        phase_nxt = PH_LEN;
      end
    endcase
  end

  assign verdict.valid = take && last_byte;
  assign verdict.found = found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEN;
      bytes_left_r <= '0;
      in_list_r    <= 1'b0;
      pairs_left_r <= '0;
      low_half_r   <= '0;
      half_sel_r   <= 1'b0;
      found_r      <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        phase_r      <= PH_LEN;
        bytes_left_r <= '0;
        in_list_r    <= 1'b0;
        pairs_left_r <= '0;
        low_half_r   <= '0;
        half_sel_r   <= 1'b0;
        found_r      <= 1'b0;
      end else begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        in_list_r    <= in_list_nxt;
        pairs_left_r <= pairs_left_nxt;
        low_half_r   <= low_half_nxt;
        half_sel_r   <= half_sel_nxt;
        found_r      <= found_nxt;
      end
    end
  end

  `AST_NEXT(a_report_end_clears, clk, rst_n, take && last_byte,
            (phase_r == PH_LEN) && !found_r)
  `AST_IMPL(a_found_only_when_done, clk, rst_n, found_r, phase_r == PH_DONE)
  `AST_IMPL(a_list_has_pairs, clk, rst_n, (phase_r == PH_DATA) && in_list_r,
            pairs_left_r != 7'd0)

endmodule

// ===== sv/adv_data_uuid16_scanner.sv =====
// ---------------------------------------------------------------------------
// adv_data_uuid16_scanner
// The verdict enters the result buffer on the last byte's transfer, out_found
// shows it after older verdicts pop. Throughput: one byte per cycle unless the
// two-entry result buffer is full; it keeps input open while one verdict waits.
// Reset (synchronous, rst_n low): parser idle, result buffer empty, registers
// back to UUID 0x1814 and list types 3 and 2.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adv_data_uuid16_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aduu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aduu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aduu_pkg::*;

  cfg_t       cfg_r;
  verdict_t   verdict;
  logic       take;
  logic       push;
  logic       pop;
  logic [1:0] cnt_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] buf_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_uuid          <= TARGET_UUID_RST;
      cfg_r.list_type_complete   <= LIST_TYPE_COMPLETE_RST;
      cfg_r.list_type_incomplete <= LIST_TYPE_INCOMPLETE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_UUID:          cfg_r.target_uuid          <= cfg_data;
        REG_LIST_TYPE_COMPLETE:   cfg_r.list_type_complete   <= cfg_data[7:0];
        REG_LIST_TYPE_INCOMPLETE: cfg_r.list_type_incomplete <= cfg_data[7:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign take     = in_valid && in_ready;

  aduu_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg_r),
    .verdict   (verdict)
  );

  // two-entry result buffer
  assign push      = verdict.valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_found = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= verdict.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  `AST_IMPL(a_cnt_in_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
  `AST_IMPL(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid && (cnt_r == 2'd2))
  `AST_NEXT(a_fill_second_slot, clk, rst_n, push && !pop && (cnt_r == 2'd1),
            (cnt_r == 2'd2) && (wr_ptr_r == rd_ptr_r))

endmodule
